FILE: sv/twq_pkg.sv
// ----------------------------------------------------------------------------
// twq_pkg
// Shared types and constants for the two-queue WFQ / strict-priority scheduler.
// ----------------------------------------------------------------------------
package twq_pkg;

  // Request and result payloads
  typedef struct packed {
    logic        opcode;
    logic        queue_select;
    logic [63:0] arrival_time;
    logic [15:0] packet_length;
    logic [15:0] packet_handle;
  } twq_in_t;

  typedef struct packed {
    logic        sent;
    logic        sent_queue;
    logic [15:0] sent_handle;
    logic        enqueue_dropped;
  } twq_out_t;

  // Opcodes
  localparam logic OP_ENQUEUE  = 1'b0;
  localparam logic OP_SCHEDULE = 1'b1;

  // Scheduler modes
  localparam logic MODE_SP  = 1'b0;
  localparam logic MODE_WFQ = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 19;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_Q    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_RATE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CYC_PER_US = 3'd5;

  // Transmit-time arithmetic widths
  localparam int unsigned NUM_W = 50;  // len * 8 * cycles_per_us * (w0 + w1)
  localparam int unsigned DEN_W = 35;  // weight * link_rate_mbps

  // Stored entry: arrival, length, handle
  localparam int unsigned ENTRY_W = 96;

endpackage

FILE: sv/two_queue_wfq_sp_scheduler.sv
// ----------------------------------------------------------------------------
// two_queue_wfq_sp_scheduler
// Two-queue packet scheduler with strict-priority and WFQ service modes.
// ----------------------------------------------------------------------------
// Enqueue requests and schedule requests that find both queues empty
// register their result at acceptance. A schedule that sends without a
// departure estimate also waits for the entry RAM read before its result.
// A WFQ schedule with both queues occupied reads both heads from the single
// entry RAM. It then runs, for each queue, three steps on one shared
// multiplier followed by a restoring divider that retires one of 50 quotient
// bits per cycle, and the two divisions run one after the other. A queue
// whose weight is zero, or a zero link rate, skips its multiplier steps and
// division and gets the largest departure estimate. The block takes no new
// request while one is in progress. A finished result may wait in the output
// register while the next request is taken. If that request's result is
// ready at once, it waits in a holding register until the output register
// is free.
// ----------------------------------------------------------------------------
module two_queue_wfq_sp_scheduler import twq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  twq_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output twq_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RAM_D = 2 * QUEUE_DEPTH;
  localparam int unsigned ADDR_W = $clog2(RAM_D);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_POP    = 4'd1;
  localparam logic [3:0] ST_HEAD0  = 4'd2;
  localparam logic [3:0] ST_HEAD1  = 4'd3;
  localparam logic [3:0] ST_MUL1   = 4'd4;
  localparam logic [3:0] ST_MUL2   = 4'd5;
  localparam logic [3:0] ST_MUL3   = 4'd6;
  localparam logic [3:0] ST_DSTART = 4'd7;
  localparam logic [3:0] ST_DIV    = 4'd8;
  localparam logic [3:0] ST_FINISH = 4'd9;
  localparam logic [3:0] ST_HOLD   = 4'd10;

  // Configuration
  logic        mode;
  logic        high_q;
  logic [15:0] weight [2];
  logic [18:0] link_rate;
  logic [13:0] cyc_per_us;

  // Queue pointers
  logic [PTR_W-1:0] head [2];
  logic [PTR_W-1:0] tail [2];
  logic [CNT_W-1:0] fill [2];

  logic [3:0]  state;
  logic        pick;
  logic        cq;
  logic [63:0] arr_h [2];
  logic [15:0] len_h [2];
  logic [15:0] hdl_h [2];
  logic [63:0] dep [2];
  logic [29:0] p1;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  twq_out_t    pend_data;

  logic                accept;
  logic                slot_free;
  logic                ne0;
  logic                ne1;
  logic                full;
  logic                imm_res;
  twq_out_t            imm_data;
  logic                res_load;
  logic                ram_wr;
  logic [ADDR_W-1:0]   wr_addr;
  logic                ram_rd;
  logic [ADDR_W-1:0]   rd_addr;
  logic                rd_q;
  logic [ENTRY_W-1:0]  rd_data;
  logic [29:0]         mul_a;
  logic [18:0]         mul_b;
  logic [48:0]         prod;
  logic                div_done;
  logic [NUM_W-1:0]    quot;
  logic [64:0]         dep_sum;
  logic                pop;
  logic                pop_q;

  function automatic logic [ADDR_W-1:0] slot_addr(logic q, logic [PTR_W-1:0] p);
    return q ? ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p) : ADDR_W'(p);
  endfunction

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign ne0       = fill[0] != '0;
  assign ne1       = fill[1] != '0;
  assign full      = fill[in_data.queue_select] == CNT_W'(QUEUE_DEPTH);

  // Results known at acceptance: enqueue, or schedule with both queues empty
  assign imm_res  = (in_data.opcode == OP_ENQUEUE) || (!ne0 && !ne1);
  assign imm_data = '{sent: 1'b0, sent_queue: 1'b0, sent_handle: '0,
                      enqueue_dropped: (in_data.opcode == OP_ENQUEUE) && full};

  // Load the output register when a result is ready and the register is free
  assign res_load = slot_free &&
                    ((accept && imm_res) || (state == ST_POP) ||
                     (state == ST_FINISH) || (state == ST_HOLD));

  // Entry RAM write on enqueue
  assign ram_wr  = accept && (in_data.opcode == OP_ENQUEUE) && !full;
  assign wr_addr = slot_addr(in_data.queue_select, tail[in_data.queue_select]);

  // Head read: the chosen queue in idle, queue one after the first head
  always_comb begin
    rd_q = 1'b0;
    if (state == ST_HEAD0) begin
      rd_q = 1'b1;
    end else if (mode == MODE_SP) begin
      rd_q = ne0 && ne1 ? high_q : ne1;
    end else begin
      rd_q = !ne0;
    end
  end
  assign ram_rd  = (accept && in_data.opcode == OP_SCHEDULE) || (state == ST_HEAD0);
  assign rd_addr = slot_addr(rd_q, head[rd_q]);

  twq_ram #(.WIDTH(ENTRY_W), .DEPTH(RAM_D)) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (wr_addr),
    .wr_data ({in_data.arrival_time, in_data.packet_length, in_data.packet_handle}),
    .rd_en   (ram_rd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared multiplier
  always_comb begin
    mul_a = {14'd0, len_h[cq]};
    mul_b = {5'd0, cyc_per_us};
    unique case (state)
      ST_MUL2: begin
        mul_a = p1;
        mul_b = {2'd0, {1'b0, weight[0]} + {1'b0, weight[1]}};
      end
      ST_MUL3: begin
        mul_a = {14'd0, weight[cq]};
        mul_b = link_rate;
      end
      default: begin
      end
    endcase
    prod = 49'(mul_a) * 49'(mul_b);
  end

  twq_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_DSTART),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  assign dep_sum = {1'b0, arr_h[cq]} + {15'd0, quot};

  // Pop at result hand-off
  assign pop   = ((state == ST_POP) || (state == ST_FINISH)) && slot_free;
  assign pop_q = (state == ST_FINISH) ? (dep[1] < dep[0]) : pick;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_WFQ;
      high_q     <= 1'b0;
      weight[0]  <= 16'd1;
      weight[1]  <= 16'd1;
      link_rate  <= 19'd10000;
      cyc_per_us <= 14'd2000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:       mode       <= cfg_data[0];
        REG_HIGH_Q:     high_q     <= cfg_data[0];
        REG_WEIGHT0:    weight[0]  <= cfg_data[15:0];
        REG_WEIGHT1:    weight[1]  <= cfg_data[15:0];
        REG_LINK_RATE:  link_rate  <= cfg_data;
        REG_CYC_PER_US: cyc_per_us <= cfg_data[13:0];
        default: begin
        end
      endcase
    end
  end

  // Queue pointers and fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      if (ram_wr) begin
        tail[in_data.queue_select] <= (tail[in_data.queue_select] == PTR_W'(QUEUE_DEPTH - 1))
                                      ? '0 : tail[in_data.queue_select] + 1'b1;
        fill[in_data.queue_select] <= fill[in_data.queue_select] + 1'b1;
      end
      if (pop) begin
        head[pop_q] <= (head[pop_q] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head[pop_q] + 1'b1;
        fill[pop_q] <= fill[pop_q] - 1'b1;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Raise valid on a new result, drop it once the result is taken
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (imm_res) begin
              if (slot_free) begin
                out_data <= imm_data;
              end else begin
                pend_data <= imm_data;
                state     <= ST_HOLD;
              end
            end else if (mode == MODE_WFQ && ne0 && ne1) begin
              state <= ST_HEAD0;
            end else begin
              pick  <= rd_q;
              state <= ST_POP;
            end
          end
        end
        ST_HOLD: begin
          if (slot_free) begin
            out_data <= pend_data;
            state    <= ST_IDLE;
          end
        end
        ST_POP: begin
          if (slot_free) begin
            out_data  <= '{sent: 1'b1, sent_queue: pick, sent_handle: rd_data[15:0],
                           enqueue_dropped: 1'b0};
            state     <= ST_IDLE;
          end
        end
        ST_HEAD0: begin
          {arr_h[0], len_h[0], hdl_h[0]} <= rd_data;
          state <= ST_HEAD1;
        end
        ST_HEAD1: begin
          {arr_h[1], len_h[1], hdl_h[1]} <= rd_data;
          cq    <= 1'b0;
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          if (weight[cq] == '0 || link_rate == '0) begin
            dep[cq] <= '1;
            cq      <= 1'b1;
            state   <= cq ? ST_FINISH : ST_MUL1;
          end else begin
            p1    <= prod[29:0];
            state <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          num   <= {prod[46:0], 3'd0};
          state <= ST_MUL3;
        end
        ST_MUL3: begin
          den   <= prod[DEN_W-1:0];
          state <= ST_DSTART;
        end
        ST_DSTART: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            dep[cq] <= dep_sum[64] ? '1 : dep_sum[63:0];
            cq      <= 1'b1;
            state   <= cq ? ST_FINISH : ST_MUL1;
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            out_data  <= '{sent: 1'b1, sent_queue: pop_q, sent_handle: hdl_h[pop_q],
                           enqueue_dropped: 1'b0};
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/twq_ram.sv
// ----------------------------------------------------------------------------
// twq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module twq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/twq_div.sv
// ----------------------------------------------------------------------------
// twq_div
// Restoring divider: one quotient bit per cycle over the numerator width.
// ----------------------------------------------------------------------------
module twq_div import twq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] divisor;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             fits;

  // Shift in the next numerator bit and trial-subtract
  always_comb begin
    rem_sh = {rem, quot[NUM_W-1]};
    diff   = rem_sh - {1'b0, divisor};
    fits   = rem_sh >= {1'b0, divisor};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient register doubles as the numerator shifter
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      divisor <= den;
      quot    <= num;
    end else if (busy) begin
      rem  <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

endmodule
